/* hw/rtl/tpd_pkg.sv */
// Shared types and constants for the touch packet decoder.
// No dependencies; the decoder top level refers to it by scoped names.
package tpd_pkg;

  // Header values and header bit positions.
  localparam logic [7:0] MT_HEADER     = 8'h0a;
  localparam int unsigned HDR_POS_BIT  = 7;
  localparam int unsigned HDR_PRES_BIT = 6;
  localparam int unsigned HDR_PLAY_BIT = 5;
  localparam int unsigned HDR_TOUCH_BIT = 0;

  // Index of the last data byte of a short and of a long position packet.
  localparam logic [2:0] LAST_IDX_SHORT = 3'd3;
  localparam logic [2:0] LAST_IDX_LONG  = 3'd4;

  localparam int unsigned AXIS_W   = 14;
  localparam int unsigned TDATA_W  = 40;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_H   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_V   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ID  = 8'd3;

  // Resolution codes from header bits 2..1.
  localparam logic [1:0] RES_11 = 2'd0;
  localparam logic [1:0] RES_12 = 2'd1;
  localparam logic [1:0] RES_13 = 2'd2;
  localparam logic [1:0] RES_14 = 2'd3;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_MOTION  = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  // Parser states, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_MTLEN  = 4'b0100,
    PH_MTSKIP = 4'b1000
  } phase_t;

  // Completed position packet waiting to be decoded.
  typedef struct packed {
    logic [1:0] res;
    logic       has_btn;
    logic       touch;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } job_t;

  // Build one axis word and scale it to 14 bits.
  function automatic logic [AXIS_W-1:0] axis_scale(input logic [7:0] hi,
                                                   input logic [7:0] lo,
                                                   input logic [1:0] res);
    logic [AXIS_W-1:0] w;
    logic [AXIS_W-1:0] r;
    w = {hi[6:0], lo[6:0]};
    case (res)
      RES_11:  r = {w[10:0], 3'b000};
      RES_12:  r = {w[11:0], 2'b00};
      RES_13:  r = {w[12:0], 1'b0};
      RES_14:  r = w;
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/touch_packet_decoder_top.sv */
// A packet's final byte goes through the job register and then the output register, which
// shows its motion result; a press or release result follows once that result is taken.
// Throughput: one byte per cycle; the single job register ahead of the output register
// sets it, and stalls input only while a decoded packet waits on a full output.
// Reset: synchronous active-low rst_n clears the parser and button state and sets the configuration to its defaults.
// Top level of the touch packet decoder; uses tpd_pkg.
module touch_packet_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream: tdata = rx_byte[7:0].
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  // Result stream: tdata = pos_x[13:0], pos_y[27:14], button[35:28], zeros[39:36].
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tpd_pkg::TDATA_W-1:0]   out_tdata,
  // tuser = event_kind[1:0].
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  // Configuration registers.
  logic       swap_axes_r;
  logic       invert_h_r;
  logic       invert_v_r;
  logic [7:0] button_id_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_axes_r <= 1'b0;
      invert_h_r  <= 1'b1;
      invert_v_r  <= 1'b1;
      button_id_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpd_pkg::CFG_SWAP_AXES: swap_axes_r <= cfg_data[0];
        tpd_pkg::CFG_INVERT_H:  invert_h_r  <= cfg_data[0];
        tpd_pkg::CFG_INVERT_V:  invert_v_r  <= cfg_data[0];
        tpd_pkg::CFG_BUTTON_ID: button_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake signals.
  logic in_xfer;
  logic out_xfer;
  logic out_final;
  logic out_load;
  logic job_move;

  // Parser state.
  tpd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] skip_cnt_r, skip_cnt_nxt;
  logic       held_r, held_nxt;
  logic [7:0] axis_r [4];

  tpd_pkg::job_t job_r, job_nxt;
  logic          job_valid_r, job_valid_nxt;
  logic          done;
  logic [2:0]    last_idx;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = !job_valid_r || job_move;
  assign last_idx  = (header_r[tpd_pkg::HDR_PRES_BIT] || header_r[tpd_pkg::HDR_PLAY_BIT])
                     ? tpd_pkg::LAST_IDX_LONG : tpd_pkg::LAST_IDX_SHORT;

  // Byte parser: moves between idle, position data and multitouch skipping.
  always_comb begin
    phase_nxt    = phase_r;
    header_nxt   = header_r;
    byte_idx_nxt = byte_idx_r;
    skip_cnt_nxt = skip_cnt_r;
    held_nxt     = held_r;
    done         = 1'b0;
    if (in_xfer) begin
      case (phase_r)
        tpd_pkg::PH_IDLE: begin
          if (in_tdata == tpd_pkg::MT_HEADER) begin
            phase_nxt = tpd_pkg::PH_MTLEN;
          end else if (in_tdata[tpd_pkg::HDR_POS_BIT]) begin
            header_nxt   = in_tdata;
            byte_idx_nxt = 3'd0;
            phase_nxt    = tpd_pkg::PH_DATA;
          end
        end
        tpd_pkg::PH_DATA: begin
          byte_idx_nxt = byte_idx_r + 3'd1;
          if (byte_idx_r == last_idx) begin
            done         = 1'b1;
            phase_nxt    = tpd_pkg::PH_IDLE;
            byte_idx_nxt = 3'd0;
            held_nxt     = header_r[tpd_pkg::HDR_TOUCH_BIT];
          end
        end
        tpd_pkg::PH_MTLEN: begin
          skip_cnt_nxt = in_tdata;
          phase_nxt    = (in_tdata == 8'd0) ? tpd_pkg::PH_IDLE : tpd_pkg::PH_MTSKIP;
        end
        tpd_pkg::PH_MTSKIP: begin
          skip_cnt_nxt = skip_cnt_r - 8'd1;
          if (skip_cnt_r == 8'd1) begin
            phase_nxt = tpd_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = tpd_pkg::PH_IDLE;
      endcase
    end
  end

  // Job register: a completed packet's bytes, resolution and button change.
  always_comb begin
    job_nxt.res     = header_r[2:1];
    job_nxt.touch   = header_r[tpd_pkg::HDR_TOUCH_BIT];
    job_nxt.has_btn = header_r[tpd_pkg::HDR_TOUCH_BIT] != held_r;
    job_nxt.b0      = axis_r[0];
    job_nxt.b1      = axis_r[1];
    job_nxt.b2      = axis_r[2];
    job_nxt.b3      = (byte_idx_r == tpd_pkg::LAST_IDX_SHORT) ? in_tdata : axis_r[3];
    job_valid_nxt   = done || (job_valid_r && !job_move);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tpd_pkg::PH_IDLE;
      header_r    <= 8'd0;
      byte_idx_r  <= 3'd0;
      skip_cnt_r  <= 8'd0;
      held_r      <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      header_r    <= header_nxt;
      byte_idx_r  <= byte_idx_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
      held_r      <= held_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  // Data bytes one to four are stored; the fifth is only counted.
  always_ff @(posedge clk) begin
    if (in_xfer && phase_r == tpd_pkg::PH_DATA && !byte_idx_r[2]) begin
      axis_r[byte_idx_r[1:0]] <= in_tdata;
    end
    if (done) begin
      job_r <= job_nxt;
    end
  end

  // Decode: scale both axis words, route them and invert each as configured.
  logic [tpd_pkg::AXIS_W-1:0] d1, d2, x_dec, y_dec;

  always_comb begin
    d1    = tpd_pkg::axis_scale(job_r.b0, job_r.b1, job_r.res);
    d2    = tpd_pkg::axis_scale(job_r.b2, job_r.b3, job_r.res);
    x_dec = swap_axes_r ? d1 : d2;
    y_dec = swap_axes_r ? d2 : d1;
    if (invert_h_r) x_dec = ~x_dec;
    if (invert_v_r) y_dec = ~y_dec;
  end

  // Output register: a motion result, then an optional button result.
  logic                       out_valid_r;
  logic                       out_sel_r;
  logic                       out_has_btn_r;
  tpd_pkg::kind_t             out_btn_kind_r;
  logic [tpd_pkg::AXIS_W-1:0] out_x_r, out_y_r;
  logic [7:0]                 out_btn_r;

  assign out_xfer  = out_tvalid && out_tready;
  assign out_final = out_sel_r || !out_has_btn_r;
  assign out_load  = !out_valid_r || (out_xfer && out_final);
  assign job_move  = job_valid_r && out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_sel_r   <= 1'b0;
    end else if (job_move) begin
      out_valid_r <= 1'b1;
      out_sel_r   <= 1'b0;
    end else if (out_xfer) begin
      if (out_final) begin
        out_valid_r <= 1'b0;
        out_sel_r   <= 1'b0;
      end else begin
        out_sel_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_move) begin
      out_x_r        <= x_dec;
      out_y_r        <= y_dec;
      out_btn_r      <= button_id_r;
      out_has_btn_r  <= job_r.has_btn;
      out_btn_kind_r <= job_r.touch ? tpd_pkg::KIND_PRESS : tpd_pkg::KIND_RELEASE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, (out_sel_r ? out_btn_r : 8'd0), out_y_r, out_x_r};
  assign out_tuser  = out_sel_r ? out_btn_kind_r : tpd_pkg::KIND_MOTION;
  assign out_tlast  = out_final;

  // A pending job that cannot move must hold off the input side.
  a_job_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && !job_move) |-> !in_tready)
    else $error("input accepted while a decoded packet is stalled");

  // A button result is always the final result of its packet.
  a_btn_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_sel_r) |-> out_tlast)
    else $error("button result not marked last");

  // A job is never dropped: it stays until it moves to the output register.
  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && !job_move) |=> job_valid_r)
    else $error("decoded packet lost");

  // After a button result is taken, the next result starts a new motion result.
  a_btn_then_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_sel_r) |=> !out_sel_r)
    else $error("button result repeated");

endmodule
